### sv/acpem_pkg.sv
// Shared types and constants of the AC current peak and energy meter.
package acpem_pkg;

    // Fixed field widths
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned SPW_W      = 8;
    localparam int unsigned CURRENT_W  = 12;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned ENERGY_W   = 13;
    localparam int unsigned PERIOD_W   = 10;

    // Current scaling: ((high - low) * 21 - 11) / 10, capped at the 12-bit range
    localparam int unsigned CUR_MUL    = 21;
    localparam int unsigned CUR_OFFSET = 11;
    localparam int unsigned CUR_DIV    = 10;
    localparam int unsigned CUR_MAX    = 4095;

    // Energy scaling: sum / slots * 220 / 60
    localparam int unsigned ENERGY_MUL = 220;
    localparam int unsigned ENERGY_DIV = 60;

    // Period counter wraps here
    localparam int unsigned PERIOD_MOD = 1000;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5000;
    localparam logic [SPW_W-1:0]      SPW_RESET      = 8'd100;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_RECORD_INTERVAL    = 1'b0,
        REG_SAMPLES_PER_WINDOW = 1'b1
    } t_reg_idx;

    // Result of the tracking core, before energy scaling
    typedef struct packed {
        logic [CURRENT_W-1:0] current;
        logic                 updated;
        logic [SUM_W-1:0]     latched_sum;
        logic [PERIOD_W-1:0]  period;
    } t_core_res;

endpackage

### sv/acpem_core.sv
// Sample register, window min/max tracking, current recording and slot accumulation.
module acpem_core #(
    parameter int unsigned CYCLE_SLOTS = 60,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_in_stall,
    input  logic [acpem_pkg::INTERVAL_W-1:0] i_record_interval,
    input  logic [acpem_pkg::SPW_W-1:0]     i_samples_per_window,
    output logic                            o_res_valid,
    output acpem_pkg::t_core_res            o_res,
    input  logic                            i_res_ready
);
    import acpem_pkg::*;

    localparam int unsigned SLOT_W = (CYCLE_SLOTS > 2) ? $clog2(CYCLE_SLOTS) : 1;
    // Width of diff*21 - 11
    localparam int unsigned XW     = SAMPLE_BITS + 5;
    // Reciprocal of 10, exact for every value below 2^XW
    localparam int unsigned K_DIV  = XW + 4;
    localparam longint unsigned RECIP_L =
        ((64'd1 << K_DIV) + 64'(CUR_DIV) - 64'd1) / 64'(CUR_DIV);
    localparam logic [K_DIV-1:0] RECIP = K_DIV'(RECIP_L);

    // Input stage
    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    // Result stage
    logic                   r_b_valid;
    t_core_res              r_b_res;
    // Meter state
    logic [SPW_W-1:0]       r_pos;
    logic [SAMPLE_BITS-1:0] r_low;
    logic [SAMPLE_BITS-1:0] r_high;
    logic [INTERVAL_W-1:0]  r_tick;
    logic [SLOT_W-1:0]      r_slot;
    logic [CURRENT_W-1:0]   r_latest;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_latched;
    logic [PERIOD_W-1:0]    r_period;

    logic [SPW_W-1:0]       n_pos;
    logic [SAMPLE_BITS-1:0] n_low;
    logic [SAMPLE_BITS-1:0] n_high;
    logic [INTERVAL_W-1:0]  n_tick;
    logic [SLOT_W-1:0]      n_slot;
    logic [CURRENT_W-1:0]   n_latest;
    logic [SUM_W-1:0]       n_sum;
    logic [SUM_W-1:0]       n_latched;
    logic [PERIOD_W-1:0]    n_period;
    logic                   n_updated;

    logic                   ready_a;
    logic                   ready_b;
    logic                   fire_b;

    logic [XW-1:0]          diff_ext;
    logic [XW-1:0]          scaled;
    logic [XW+K_DIV-1:0]    prod;
    logic [XW-1:0]          quot;
    logic [CURRENT_W-1:0]   cur;
    logic [SLOT_W-1:0]      slot_inc;

    // Handshake: a stage loads when empty or when its contents move on
    assign ready_b    = !r_b_valid || i_res_ready;
    assign ready_a    = !r_a_valid || ready_b;
    assign fire_b     = r_a_valid && ready_b;
    assign o_in_stall = !ready_a;

    // Effective current from the window, divide by 10 through a reciprocal
    always_comb begin
        diff_ext = XW'(r_high - r_low);
        // diff * 21 as shifts and adds, then remove the offset
        scaled   = (diff_ext << 4) + (diff_ext << 2) + diff_ext - XW'(CUR_OFFSET);
        prod     = scaled * RECIP;
        quot     = prod[K_DIV +: XW];
        if (r_high <= r_low) begin
            cur = '0;
        end else if (quot > XW'(CUR_MAX)) begin
            cur = CURRENT_W'(CUR_MAX);
        end else begin
            cur = quot[CURRENT_W-1:0];
        end
    end

    assign slot_inc = (r_slot == SLOT_W'(CYCLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;

    // Next state for one sample
    always_comb begin
        n_pos     = r_pos;
        n_low     = r_low;
        n_high    = r_high;
        n_tick    = r_tick + 1'b1;
        n_slot    = r_slot;
        n_latest  = r_latest;
        n_sum     = r_sum;
        n_latched = r_latched;
        n_period  = r_period;
        n_updated = 1'b0;
        if (r_pos == '0) begin
            // open a window
            n_low  = r_a_sample;
            n_high = r_a_sample;
            n_pos  = SPW_W'(1);
        end else if (r_pos < i_samples_per_window) begin
            // track min, and max only when not a new min
            if (r_a_sample < r_low) begin
                n_low = r_a_sample;
            end else if (r_a_sample > r_high) begin
                n_high = r_a_sample;
            end
            n_pos = r_pos + 1'b1;
        end else begin
            // closing sample is dropped; record when the interval has passed
            n_pos = '0;
            if (r_tick >= i_record_interval) begin
                n_updated = 1'b1;
                n_tick    = INTERVAL_W'(1);
                n_latest  = cur;
                n_sum     = (r_slot == '0) ? SUM_W'(cur) : r_sum + SUM_W'(cur);
                n_slot    = slot_inc;
                if (slot_inc == '0) begin
                    n_latched = n_sum;
                    n_period  = (r_period == PERIOD_W'(PERIOD_MOD - 1)) ?
                                '0 : r_period + 1'b1;
                end
            end
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= i_in_valid;
        end
        if (i_in_valid && ready_a) begin
            r_a_sample <= i_sample;
        end
    end

    // Meter state, advanced once per transfer into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_tick    <= '0;
            r_slot    <= '0;
            r_latest  <= '0;
            r_sum     <= '0;
            r_latched <= '0;
            r_period  <= '0;
        end else if (fire_b) begin
            r_pos     <= n_pos;
            r_low     <= n_low;
            r_high    <= n_high;
            r_tick    <= n_tick;
            r_slot    <= n_slot;
            r_latest  <= n_latest;
            r_sum     <= n_sum;
            r_latched <= n_latched;
            r_period  <= n_period;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
        if (fire_b) begin
            r_b_res.current     <= n_latest;
            r_b_res.updated     <= n_updated;
            r_b_res.latched_sum <= n_latched;
            r_b_res.period      <= n_period;
        end
    end

    assign o_res_valid = r_b_valid;
    assign o_res       = r_b_res;

endmodule

### sv/acpem_scale.sv
// Energy scaling stages and the output register.
module acpem_scale #(
    parameter int unsigned CYCLE_SLOTS = 60
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  acpem_pkg::t_core_res             i_res,
    output logic                             o_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [acpem_pkg::CURRENT_W-1:0]  o_current_now,
    output logic                             o_current_updated,
    output logic [acpem_pkg::ENERGY_W-1:0]   o_period_energy,
    output logic [acpem_pkg::PERIOD_W-1:0]   o_period_number
);
    import acpem_pkg::*;

    // Reciprocal of the slot count, exact for any sum below 2^SUM_W
    localparam int unsigned K_SL = SUM_W + 7;
    localparam longint unsigned RECIP_SL_L =
        ((64'd1 << K_SL) + 64'(CYCLE_SLOTS) - 64'd1) / 64'(CYCLE_SLOTS);
    localparam logic [K_SL-1:0] RECIP_SL = K_SL'(RECIP_SL_L);

    // 220/60 reduces to 11/3 = 3 + 2/3; reciprocal of 3 exact below 2^(SUM_W+1)
    localparam int unsigned RED_DEN = ENERGY_DIV / 20;
    localparam int unsigned RED_NUM = ENERGY_MUL / 20;
    localparam int unsigned WHOLE   = RED_NUM / RED_DEN;
    localparam int unsigned FRAC    = RED_NUM % RED_DEN;
    localparam int unsigned XW3     = SUM_W + 2;
    localparam int unsigned K_3     = XW3 + 2;
    localparam longint unsigned RECIP_3_L =
        ((64'd1 << K_3) + 64'(RED_DEN) - 64'd1) / 64'(RED_DEN);
    localparam logic [K_3-1:0] RECIP_3 = K_3'(RECIP_3_L);

    logic                  r_c_valid;
    logic [CURRENT_W-1:0]  r_c_current;
    logic                  r_c_updated;
    logic [PERIOD_W-1:0]   r_c_period;
    logic [SUM_W-1:0]      r_c_quot;

    logic                  r_d_valid;
    logic [CURRENT_W-1:0]  r_d_current;
    logic                  r_d_updated;
    logic [PERIOD_W-1:0]   r_d_period;
    logic [ENERGY_W-1:0]   r_d_energy;

    logic                  ready_c;
    logic                  ready_d;
    logic                  fire_c;
    logic                  fire_d;

    logic [SUM_W+K_SL-1:0] prod_sl;
    logic [SUM_W-1:0]      n_quot;
    logic [XW3-1:0]        whole_part;
    logic [XW3-1:0]        frac_num;
    logic [XW3+K_3-1:0]    prod_3;
    logic [XW3-1:0]        frac_part;
    logic [XW3-1:0]        n_energy;

    assign ready_d = !r_d_valid || !i_out_stall;
    assign ready_c = !r_c_valid || ready_d;
    assign fire_c  = i_valid && ready_c;
    assign fire_d  = r_c_valid && ready_d;
    assign o_ready = ready_c;

    // Per-slot average of the latched sum
    assign prod_sl = i_res.latched_sum * RECIP_SL;
    assign n_quot  = prod_sl[K_SL +: SUM_W];

    // Scale the average by 11/3
    assign whole_part = XW3'(r_c_quot) * XW3'(WHOLE);
    assign frac_num   = XW3'(r_c_quot) * XW3'(FRAC);
    assign prod_3     = frac_num * RECIP_3;
    assign frac_part  = prod_3[K_3 +: XW3];
    assign n_energy   = whole_part + frac_part;

    // Average stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= i_valid;
        end
        if (fire_c) begin
            r_c_current <= i_res.current;
            r_c_updated <= i_res.updated;
            r_c_period  <= i_res.period;
            r_c_quot    <= n_quot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (ready_d) begin
            r_d_valid <= r_c_valid;
        end
        if (fire_d) begin
            r_d_current <= r_c_current;
            r_d_updated <= r_c_updated;
            r_d_period  <= r_c_period;
            r_d_energy  <= n_energy[ENERGY_W-1:0];
        end
    end

    assign o_out_valid       = r_d_valid;
    assign o_current_now     = r_d_current;
    assign o_current_updated = r_d_updated;
    assign o_period_energy   = r_d_energy;
    assign o_period_number   = r_d_period;

endmodule

### sv/ac_current_peak_energy_meter.sv
// Top level of the AC current peak and energy meter: configuration registers and pipeline.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_stall   | i_adc_sample
//  output   | o_out_valid / i_out_stall | o_current_now, o_current_updated,
//           |                           | o_period_energy, o_period_number
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One sample is taken per cycle while o_in_stall is low; a result passes in turn through the
// sample register, tracking stage, average stage and output register.
// The current multiply is in the tracking stage; the 11/3 multiplies share the last stage.
// Reset is synchronous and clears all meter state; registers return to 5000 and 100.
// Each stage loads when empty or when its contents move on, so an output stall reaches
// the input only once every stage holds a transfer.
module ac_current_peak_energy_meter #(
    parameter int unsigned CYCLE_SLOTS = 60,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_adc_sample,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [acpem_pkg::CURRENT_W-1:0] o_current_now,
    output logic                            o_current_updated,
    output logic [acpem_pkg::ENERGY_W-1:0]  o_period_energy,
    output logic [acpem_pkg::PERIOD_W-1:0]  o_period_number,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import acpem_pkg::*;

    logic [INTERVAL_W-1:0] r_record_interval;
    logic [SPW_W-1:0]      r_samples_per_window;
    logic                  cfg_write;
    t_reg_idx              reg_idx;

    logic                  res_valid;
    logic                  res_ready;
    t_core_res             res;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_interval    <= INTERVAL_RESET;
            r_samples_per_window <= SPW_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_RECORD_INTERVAL:    r_record_interval    <= pwdata[INTERVAL_W-1:0];
                REG_SAMPLES_PER_WINDOW: r_samples_per_window <= pwdata[SPW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_idx)
            REG_RECORD_INTERVAL:    prdata = 32'(r_record_interval);
            REG_SAMPLES_PER_WINDOW: prdata = 32'(r_samples_per_window);
            default:                prdata = '0;
        endcase
    end

    acpem_core #(
        .CYCLE_SLOTS (CYCLE_SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_sample             (i_adc_sample),
        .o_in_stall           (o_in_stall),
        .i_record_interval    (r_record_interval),
        .i_samples_per_window (r_samples_per_window),
        .o_res_valid          (res_valid),
        .o_res                (res),
        .i_res_ready          (res_ready)
    );

    acpem_scale #(
        .CYCLE_SLOTS (CYCLE_SLOTS)
    ) u_scale (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (res_valid),
        .i_res             (res),
        .o_ready           (res_ready),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_current_now     (o_current_now),
        .o_current_updated (o_current_updated),
        .o_period_energy   (o_period_energy),
        .o_period_number   (o_period_number)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the AC current peak and energy meter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acpem_pkg::*;

    localparam int unsigned SLOT_COUNT    = 60;
    localparam int unsigned SAMPLE_W      = 10;
    localparam int unsigned HALF_PERIOD   = 6;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned MAX_REPORTS   = 50;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam int unsigned RESET_SAMPLES = 200;
    localparam int unsigned FULL_RATE_SAMPLES = 240;
    localparam int unsigned RANDOM_PHASES = 9;
    localparam int unsigned PHASE_SAMPLES = 130;
    localparam int unsigned PRESSURE_PHASE = 4;

    typedef enum int unsigned {
        SPREAD_UNIFORM,
        SPREAD_RAILS,
        SPREAD_NARROW,
        SPREAD_FLAT
    } t_sample_spread;

    typedef struct packed {
        logic [CURRENT_W-1:0] current_now;
        logic                 updated;
        logic [ENERGY_W-1:0]  energy;
        logic [PERIOD_W-1:0]  period_number;
    } t_meter_reading;

    // Track meter state and queue the reading predicted for every sample transfer
    class t_meter_scoreboard;
        int unsigned      mismatches;
        t_meter_reading   expected_readings[$];

        logic [INTERVAL_W-1:0] record_interval;
        logic [SPW_W-1:0]      window_length;

        logic [7:0]            window_pos;
        logic [SAMPLE_W-1:0]   low_mark;
        logic [SAMPLE_W-1:0]   high_mark;
        logic [INTERVAL_W-1:0] tick_count;
        logic [5:0]            slot;
        logic [CURRENT_W-1:0]  latest_current;
        logic [SUM_W-1:0]      running_sum;
        logic [SUM_W-1:0]      latched_sum;
        logic [PERIOD_W-1:0]   period_count;

        function new();
            mismatches       = 0;
            record_interval  = INTERVAL_RESET;
            window_length    = SPW_RESET;
            window_pos       = '0;
            low_mark         = '0;
            high_mark        = '0;
            tick_count       = '0;
            slot             = '0;
            latest_current   = '0;
            running_sum      = '0;
            latched_sum      = '0;
            period_count     = '0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_RECORD_INTERVAL:    record_interval = value[INTERVAL_W-1:0];
                REG_SAMPLES_PER_WINDOW: window_length   = value[SPW_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_tick(logic [SAMPLE_W-1:0] sample);
            t_meter_reading       reading;
            int unsigned          span;
            logic [CURRENT_W-1:0] current;
            reading.updated = 1'b0;
            if (window_pos == 0) begin
                // open a window
                low_mark   = sample;
                high_mark  = sample;
                window_pos = 8'd1;
            end else if (window_pos < window_length) begin
                // a sample below the low mark never touches the high mark
                if (sample < low_mark)
                    low_mark = sample;
                else if (sample > high_mark)
                    high_mark = sample;
                window_pos = window_pos + 8'd1;
            end else begin
                // closing sample: discard it, record if the interval has passed
                if (tick_count >= record_interval) begin
                    if (high_mark <= low_mark) begin
                        current = '0;
                    end else begin
                        span    = high_mark - low_mark;
                        span    = (span * CUR_MUL - CUR_OFFSET) / CUR_DIV;
                        current = CURRENT_W'((span > CUR_MAX) ? CUR_MAX : span);
                    end
                    tick_count      = '0;
                    reading.updated = 1'b1;
                    if (slot == 0)
                        running_sum = '0;
                    latest_current = current;
                    running_sum    = running_sum + SUM_W'(current);
                    slot           = (slot == SLOT_COUNT - 1) ? 6'd0 : slot + 6'd1;
                    // latch the sum once a full cycle of slots is in
                    if (slot == 0) begin
                        period_count = (period_count == PERIOD_MOD - 1) ?
                                       '0 : period_count + 1'b1;
                        latched_sum  = running_sum;
                    end
                end
                window_pos = '0;
            end
            tick_count            = tick_count + 1'b1;
            reading.current_now   = latest_current;
            reading.energy        = ENERGY_W'(latched_sum / SLOT_COUNT * ENERGY_MUL / ENERGY_DIV);
            reading.period_number = period_count;
            expected_readings.push_back(reading);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("error at %0t: %s", $realtime, what);
        endtask

        task check_reading(t_meter_reading got);
            t_meter_reading want;
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("reading with none pending: current %0d",
                                          got.current_now));
                return;
            end
            want = expected_readings.pop_front();
            if (got.current_now !== want.current_now)
                report_mismatch($sformatf("current_now %0d, predicted %0d",
                                          got.current_now, want.current_now));
            if (got.updated !== want.updated)
                report_mismatch($sformatf("current_updated %0b, predicted %0b",
                                          got.updated, want.updated));
            if (got.energy !== want.energy)
                report_mismatch($sformatf("period_energy %0d, predicted %0d",
                                          got.energy, want.energy));
            if (got.period_number !== want.period_number)
                report_mismatch($sformatf("period_number %0d, predicted %0d",
                                          got.period_number, want.period_number));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_adc_sample  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [CURRENT_W-1:0]  o_current_now;
    logic                  o_current_updated;
    logic [ENERGY_W-1:0]   o_period_energy;
    logic [PERIOD_W-1:0]   o_period_number;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [2:0]            paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    t_meter_scoreboard meter_sb = new();

    logic            idle_on     = 1'b1;
    logic            hold_go     = 1'b0;
    logic            hold_done   = 1'b0;
    int unsigned     stall_left  = 0;
    int unsigned     cycle_count = 0;
    t_sample_spread  spread      = SPREAD_UNIFORM;
    int unsigned     band_center = 0;

    ac_current_peak_energy_meter #(
        .CYCLE_SLOTS (SLOT_COUNT),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_adc_sample      (i_adc_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_current_now     (o_current_now),
        .o_current_updated (o_current_updated),
        .o_period_energy   (o_period_energy),
        .o_period_number   (o_period_number),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int unsigned lo;
        int unsigned hi;
        case (spread)
            SPREAD_RAILS: begin
                if ($urandom_range(0, 1) == 0)
                    return SAMPLE_W'($urandom_range(0, 15));
                return SAMPLE_W'($urandom_range(1008, 1023));
            end
            SPREAD_NARROW: begin
                lo = (band_center > 3) ? band_center - 3 : 0;
                hi = (band_center + 3 > 1023) ? 1023 : band_center + 3;
                return SAMPLE_W'($urandom_range(lo, hi));
            end
            SPREAD_FLAT:    return SAMPLE_W'(band_center);
            default:        return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check each result transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        t_meter_reading got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.current_now   = o_current_now;
            got.updated       = o_current_updated;
            got.energy        = o_period_energy;
            got.period_number = o_period_number;
            meter_sb.check_reading(got);
        end
        if (hold_go && !hold_done) begin
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on)
                stall_left = pick_gap();
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up into the input
    initial begin
        wait (hold_go);
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_done <= 1'b1;
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        i_in_valid   <= 1'b1;
        i_adc_sample <= value;
        do @(posedge i_clk); while (o_in_stall);
        meter_sb.predict_tick(value);
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_samples(int unsigned count);
        repeat (count) send_sample(next_sample());
    endtask

    // Drop valid and let every pending reading come out
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (meter_sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] width_mask;
        wait_until_idle();
        width_mask = (idx == REG_RECORD_INTERVAL) ?
                     (32'd1 << INTERVAL_W) - 1 : (32'd1 << SPW_W) - 1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        meter_sb.set_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            readback = prdata;
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((readback & width_mask) !== (value & width_mask))
            meter_sb.report_mismatch($sformatf("register %s reads %0d, written %0d",
                                               idx.name(), readback & width_mask,
                                               value & width_mask));
    endtask

    task automatic configure(logic [INTERVAL_W-1:0] interval, logic [SPW_W-1:0] window);
        write_register(REG_RECORD_INTERVAL, 32'(interval));
        write_register(REG_SAMPLES_PER_WINDOW, 32'(window));
    endtask

    initial begin
        int unsigned          window_cases[15] = '{0, 1023, 600,  1023, 0, 17,  5, 5, 0,
                                                   5, 6, 1023,  1023, 1023, 0};
        int unsigned          interval_cases[6] = '{100, 200, 300,  400, 50, 900};
        logic [INTERVAL_W-1:0] interval_val;
        logic [SPW_W-1:0]      window_val;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: windows close but nothing records before 5000 ticks
        spread = SPREAD_UNIFORM;
        send_samples(RESET_SAMPLES);

        // extreme spans, equal samples and a new low after the opening sample
        configure(16'd0, 8'd2);
        while (meter_sb.window_pos != 0)
            send_sample('0);
        foreach (window_cases[k])
            send_sample(SAMPLE_W'(window_cases[k]));

        // windows of length zero and one both close on the second sample
        write_register(REG_SAMPLES_PER_WINDOW, 32'd0);
        send_sample(SAMPLE_W'(7));
        send_sample(SAMPLE_W'(9));
        write_register(REG_SAMPLES_PER_WINDOW, 32'd1);
        send_sample(SAMPLE_W'(9));
        send_sample(SAMPLE_W'(1));

        // first window closes before the interval, the second records
        configure(16'd4, 8'd2);
        foreach (interval_cases[k])
            send_sample(SAMPLE_W'(interval_cases[k]));

        // complete a couple of periods at full rate
        idle_on <= 1'b0;
        configure(16'd0, 8'd0);
        send_samples(FULL_RATE_SAMPLES);

        // random settings and sample spreads
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    interval_val = 16'd1;
                    window_val   = 8'd2;
                end
                1: begin
                    interval_val = 16'hFFFF;
                    window_val   = 8'd255;
                end
                default: begin
                    interval_val = ($urandom_range(0, 3) == 0) ?
                                   INTERVAL_W'($urandom_range(13, 400)) :
                                   INTERVAL_W'($urandom_range(0, 12));
                    window_val   = ($urandom_range(0, 9) == 0) ?
                                   SPW_W'($urandom_range(0, 1)) :
                                   SPW_W'($urandom_range(2, 6));
                end
            endcase
            idle_on <= (phase % 3 != 2);
            configure(interval_val, window_val);
            spread      = t_sample_spread'($urandom_range(0, 3));
            band_center = $urandom_range(0, 1023);
            if (phase == PRESSURE_PHASE)
                hold_go <= 1'b1;
            send_samples(PHASE_SAMPLES);
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (meter_sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
